/* hdl/nls_pkg.sv */
package nls_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [7:0] char_t;
  typedef logic [1:0] gb_t;
  typedef logic [3:0] err_t;

  localparam kind_t KIND_CHAR = 2'd0;
  localparam kind_t KIND_FIN  = 2'd1;
  localparam kind_t KIND_REJ  = 2'd2;

  localparam err_t ERR_NONE      = 4'd0;
  localparam err_t ERR_NO_DIGITS = 4'd1;
  localparam err_t ERR_EXP2      = 4'd2;
  localparam err_t ERR_AFTER_E   = 4'd3;
  localparam err_t ERR_AFTER_SGN = 4'd4;
  localparam err_t ERR_AFTER_US  = 4'd5;
  localparam err_t ERR_DOT_EXP   = 4'd6;
  localparam err_t ERR_DOT2      = 4'd7;
  localparam err_t ERR_GLUED     = 4'd8;

  localparam char_t CH_0     = 8'h30;
  localparam char_t CH_1     = 8'h31;
  localparam char_t CH_7     = 8'h37;
  localparam char_t CH_9     = 8'h39;
  localparam char_t CH_LO_A  = 8'h61;
  localparam char_t CH_UP_A  = 8'h41;
  localparam char_t CH_LO_B  = 8'h62;
  localparam char_t CH_UP_B  = 8'h42;
  localparam char_t CH_LO_D  = 8'h64;
  localparam char_t CH_UP_D  = 8'h44;
  localparam char_t CH_LO_E  = 8'h65;
  localparam char_t CH_UP_E  = 8'h45;
  localparam char_t CH_LO_F  = 8'h66;
  localparam char_t CH_UP_F  = 8'h46;
  localparam char_t CH_LO_L  = 8'h6c;
  localparam char_t CH_UP_L  = 8'h4c;
  localparam char_t CH_LO_O  = 8'h6f;
  localparam char_t CH_UP_O  = 8'h4f;
  localparam char_t CH_LO_U  = 8'h75;
  localparam char_t CH_UP_U  = 8'h55;
  localparam char_t CH_LO_X  = 8'h78;
  localparam char_t CH_UP_X  = 8'h58;
  localparam char_t CH_LO_Z  = 8'h7a;
  localparam char_t CH_UP_Z  = 8'h5a;
  localparam char_t CH_UNDER = 8'h5f;
  localparam char_t CH_DOT   = 8'h2e;
  localparam char_t CH_PLUS  = 8'h2b;
  localparam char_t CH_MINUS = 8'h2d;

  typedef struct packed {
    kind_t kind;
    char_t char_out;
    gb_t   give_back;
    err_t  error_code;
    logic  last;
  } result_t;

  function automatic logic is_digit(char_t c);
    return c inside {[CH_0:CH_9]};
  endfunction

  function automatic logic is_alpha(char_t c);
    return c inside {[CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z]};
  endfunction

  function automatic logic is_lu(char_t c);
    return c inside {CH_LO_L, CH_UP_L, CH_LO_U, CH_UP_U};
  endfunction

  function automatic result_t mk_char(char_t c);
    result_t r;
    r = '0;
    r.kind = KIND_CHAR;
    r.char_out = c;
    return r;
  endfunction

  function automatic result_t mk_fin(gb_t gb);
    result_t r;
    r = '0;
    r.kind = KIND_FIN;
    r.give_back = gb;
    return r;
  endfunction

  function automatic result_t mk_rej(err_t e);
    result_t r;
    r = '0;
    r.kind = KIND_REJ;
    r.error_code = e;
    return r;
  endfunction

endpackage

/* hdl/nls_if.sv */
interface nls_in_if import nls_pkg::*;;
  logic  valid;
  logic  ready;
  logic  begin_req;
  char_t ch;
  logic  line_end;

  modport source (output valid, output begin_req, output ch, output line_end, input ready);
  modport sink (input valid, input begin_req, input ch, input line_end, output ready);
endinterface

interface nls_out_if import nls_pkg::*;;
  logic  valid;
  logic  ready;
  kind_t kind;
  char_t char_out;
  gb_t   give_back;
  err_t  error_code;
  logic  last;

  modport source (output valid, output kind, output char_out, output give_back,
                  output error_code, output last, input ready);
  modport sink (input valid, input kind, input char_out, input give_back,
                input error_code, input last, output ready);
endinterface

/* hdl/numeric_literal_scanner_core.sv */
// Numeric literal scanner: one character word is taken per clock into an input register
// while the register is free or being consumed, decoded against the scan state and its
// results (zero, one or two words) pushed into a four-entry result queue that drives the
// output channel. A word is consumed whenever the queue holds two entries or fewer, so
// with the output side ready the block sustains one character per cycle; the two results
// of a character that yields two (a held '.', 'e' or sign being confirmed) are absorbed
// by the queue. Results pass from the input register through the queue to the output.
module numeric_literal_scanner_core import nls_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  nls_in_if.sink     in_ch,
  nls_out_if.source  out_ch
);

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_ZERO  = 4'd1;
  localparam logic [3:0] PH_DEC   = 4'd2;
  localparam logic [3:0] PH_HEX   = 4'd3;
  localparam logic [3:0] PH_BIN   = 4'd4;
  localparam logic [3:0] PH_OCT   = 4'd5;
  localparam logic [3:0] PH_DOT1  = 4'd6;
  localparam logic [3:0] PH_DOT2  = 4'd7;
  localparam logic [3:0] PH_EXPLO = 4'd8;
  localparam logic [3:0] PH_EXPUP = 4'd9;
  localparam logic [3:0] PH_SIGN  = 4'd10;
  localparam logic [3:0] PH_UNDER = 4'd11;
  localparam logic [3:0] PH_SUFD1 = 4'd12;
  localparam logic [3:0] PH_SUFD2 = 4'd13;
  localparam logic [3:0] PH_SUFR1 = 4'd14;
  localparam logic [3:0] PH_CHECK = 4'd15;

  // input register
  logic  in_valid_r, in_valid_nxt;
  logic  begin_r;
  char_t ch_r;
  logic  eol_r;

  // scan state
  logic [3:0] phase_r, phase_nxt;
  logic       point_r, point_nxt;
  logic       exp_r, exp_nxt;
  logic       rdig_r, rdig_nxt;
  logic       minus_r, minus_nxt;

  // result queue
  result_t    fifo_r [4];
  logic [1:0] wptr_r, wptr_nxt;
  logic [1:0] rptr_r, rptr_nxt;
  logic [2:0] count_r, count_nxt;

  result_t    res0, res1;
  logic [1:0] cnt;
  logic       dec_go;
  logic       consume, accept, pop;

  assign consume      = in_valid_r && (count_r <= 3'd2);
  assign in_ch.ready  = !in_valid_r || consume;
  assign accept       = in_ch.valid && in_ch.ready;
  assign in_valid_nxt = accept ? 1'b1 : (consume ? 1'b0 : in_valid_r);

  assign out_ch.valid      = (count_r != 3'd0);
  assign out_ch.kind       = fifo_r[rptr_r].kind;
  assign out_ch.char_out   = fifo_r[rptr_r].char_out;
  assign out_ch.give_back  = fifo_r[rptr_r].give_back;
  assign out_ch.error_code = fifo_r[rptr_r].error_code;
  assign out_ch.last       = fifo_r[rptr_r].last;
  assign pop               = out_ch.valid && out_ch.ready;

  always_comb begin
    phase_nxt = phase_r;
    point_nxt = point_r;
    exp_nxt   = exp_r;
    rdig_nxt  = rdig_r;
    minus_nxt = minus_r;
    res0      = '0;
    res1      = '0;
    cnt       = 2'd0;
    dec_go    = 1'b0;

    if (begin_r) begin
      point_nxt = 1'b0;
      exp_nxt   = 1'b0;
      rdig_nxt  = 1'b0;
      minus_nxt = 1'b0;
      if (eol_r) begin
        phase_nxt = PH_IDLE;
      end else begin
        res0      = mk_char(ch_r);
        cnt       = 2'd1;
        phase_nxt = (ch_r == CH_0) ? PH_ZERO : PH_DEC;
      end
    end else if (phase_r == PH_IDLE) begin
      cnt = 2'd0;
    end else if (eol_r) begin
      cnt       = 2'd1;
      phase_nxt = PH_IDLE;
      case (phase_r)
        PH_HEX, PH_BIN, PH_OCT: begin
          res0 = rdig_r ? mk_fin(2'd0) : mk_rej(ERR_NO_DIGITS);
        end
        PH_DOT1, PH_DOT2, PH_EXPLO, PH_EXPUP, PH_SIGN, PH_UNDER: begin
          res0 = mk_fin(2'd1);
        end
        default: begin
          res0 = mk_fin(2'd0);
        end
      endcase
    end else begin
      case (phase_r)
        PH_ZERO: begin
          if (ch_r inside {CH_LO_X, CH_UP_X}) begin
            res0 = mk_char(ch_r); cnt = 2'd1; phase_nxt = PH_HEX;
          end else if (ch_r inside {CH_LO_B, CH_UP_B}) begin
            res0 = mk_char(ch_r); cnt = 2'd1; phase_nxt = PH_BIN;
          end else if (ch_r inside {CH_LO_O, CH_UP_O}) begin
            res0 = mk_char(ch_r); cnt = 2'd1; phase_nxt = PH_OCT;
          end else begin
            dec_go = 1'b1;
          end
        end
        PH_DEC: begin
          dec_go = 1'b1;
        end
        PH_HEX, PH_BIN, PH_OCT: begin
          if ((phase_r == PH_BIN && ch_r inside {CH_0, CH_1}) ||
              (phase_r == PH_OCT && ch_r inside {[CH_0:CH_7]}) ||
              (phase_r == PH_HEX &&
               ch_r inside {[CH_0:CH_9], [CH_LO_A:CH_LO_F], [CH_UP_A:CH_UP_F]})) begin
            res0 = mk_char(ch_r); cnt = 2'd1; rdig_nxt = 1'b1;
          end else if (ch_r == CH_UNDER) begin
            cnt = 2'd0;
          end else if (!rdig_r) begin
            res0 = mk_rej(ERR_NO_DIGITS); cnt = 2'd1; phase_nxt = PH_IDLE;
          end else if (is_lu(ch_r)) begin
            res0 = mk_char(ch_r); cnt = 2'd1; phase_nxt = PH_SUFR1;
          end else begin
            res0 = (is_alpha(ch_r) || is_digit(ch_r) || ch_r == CH_UNDER) ?
                   mk_rej(ERR_GLUED) : mk_fin(2'd1);
            cnt = 2'd1; phase_nxt = PH_IDLE;
          end
        end
        PH_DOT1: begin
          if (is_digit(ch_r)) begin
            res0 = mk_char(CH_DOT); res1 = mk_char(ch_r); cnt = 2'd2;
            point_nxt = 1'b1; phase_nxt = PH_DEC;
          end else begin
            res0 = mk_fin(2'd2); cnt = 2'd1; phase_nxt = PH_IDLE;
          end
        end
        PH_DOT2: begin
          res0 = is_digit(ch_r) ? mk_rej(ERR_DOT2) : mk_fin(2'd2);
          cnt = 2'd1; phase_nxt = PH_IDLE;
        end
        PH_EXPLO, PH_EXPUP: begin
          if (is_digit(ch_r)) begin
            res0 = mk_char((phase_r == PH_EXPLO) ? CH_LO_E : CH_UP_E);
            res1 = mk_char(ch_r); cnt = 2'd2; phase_nxt = PH_DEC;
          end else if (ch_r inside {CH_PLUS, CH_MINUS}) begin
            res0 = mk_char((phase_r == PH_EXPLO) ? CH_LO_E : CH_UP_E);
            cnt = 2'd1; minus_nxt = (ch_r == CH_MINUS); phase_nxt = PH_SIGN;
          end else begin
            res0 = mk_rej(ERR_AFTER_E); cnt = 2'd1; phase_nxt = PH_IDLE;
          end
        end
        PH_SIGN: begin
          if (is_digit(ch_r)) begin
            res0 = mk_char(minus_r ? CH_MINUS : CH_PLUS);
            res1 = mk_char(ch_r); cnt = 2'd2; phase_nxt = PH_DEC;
          end else begin
            res0 = mk_rej(ERR_AFTER_SGN); cnt = 2'd1; phase_nxt = PH_IDLE;
          end
        end
        PH_UNDER: begin
          if (is_digit(ch_r)) begin
            res0 = mk_char(ch_r); cnt = 2'd1; phase_nxt = PH_DEC;
          end else begin
            res0 = mk_rej(ERR_AFTER_US); cnt = 2'd1; phase_nxt = PH_IDLE;
          end
        end
        PH_SUFD1, PH_SUFD2, PH_SUFR1: begin
          if ((phase_r != PH_SUFD2 && is_lu(ch_r)) ||
              (phase_r == PH_SUFD2 && ch_r inside {CH_LO_L, CH_UP_L})) begin
            res0 = mk_char(ch_r); cnt = 2'd1;
            phase_nxt = (phase_r == PH_SUFD1) ? PH_SUFD2 : PH_CHECK;
          end else begin
            res0 = (is_alpha(ch_r) || is_digit(ch_r) || ch_r == CH_UNDER) ?
                   mk_rej(ERR_GLUED) : mk_fin(2'd1);
            cnt = 2'd1; phase_nxt = PH_IDLE;
          end
        end
        default: begin
          res0 = (is_alpha(ch_r) || is_digit(ch_r) || ch_r == CH_UNDER) ?
                 mk_rej(ERR_GLUED) : mk_fin(2'd1);
          cnt = 2'd1; phase_nxt = PH_IDLE;
        end
      endcase

      // decimal body shared by the leading zero and decimal phases
      if (dec_go) begin
        cnt = 2'd1;
        if (is_digit(ch_r)) begin
          res0 = mk_char(ch_r); phase_nxt = PH_DEC;
        end else if (ch_r inside {CH_LO_E, CH_UP_E}) begin
          if (exp_r) begin
            res0 = mk_rej(ERR_EXP2); phase_nxt = PH_IDLE;
          end else begin
            cnt = 2'd0; exp_nxt = 1'b1;
            phase_nxt = (ch_r == CH_LO_E) ? PH_EXPLO : PH_EXPUP;
          end
        end else if (ch_r == CH_UNDER) begin
          cnt = 2'd0; phase_nxt = PH_UNDER;
        end else if (ch_r == CH_DOT) begin
          if (exp_r) begin
            res0 = mk_rej(ERR_DOT_EXP); phase_nxt = PH_IDLE;
          end else begin
            cnt = 2'd0; phase_nxt = point_r ? PH_DOT2 : PH_DOT1;
          end
        end else if (ch_r inside {CH_LO_F, CH_UP_F, CH_LO_D, CH_UP_D}) begin
          res0 = mk_char(ch_r); phase_nxt = PH_CHECK;
        end else if (is_lu(ch_r)) begin
          res0 = mk_char(ch_r); phase_nxt = PH_SUFD1;
        end else if (is_alpha(ch_r)) begin
          res0 = mk_rej(ERR_GLUED); phase_nxt = PH_IDLE;
        end else begin
          res0 = mk_fin(2'd1); phase_nxt = PH_IDLE;
        end
      end
    end

    res0.last = (cnt == 2'd1);
    res1.last = 1'b1;
  end

  always_comb begin
    wptr_nxt  = (consume) ? wptr_r + cnt : wptr_r;
    rptr_nxt  = pop ? rptr_r + 2'd1 : rptr_r;
    count_nxt = count_r + ((consume) ? {1'b0, cnt} : 3'd0) - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      phase_r    <= PH_IDLE;
      point_r    <= 1'b0;
      exp_r      <= 1'b0;
      rdig_r     <= 1'b0;
      minus_r    <= 1'b0;
      wptr_r     <= '0;
      rptr_r     <= '0;
      count_r    <= '0;
    end else begin
      in_valid_r <= in_valid_nxt;
      wptr_r     <= wptr_nxt;
      rptr_r     <= rptr_nxt;
      count_r    <= count_nxt;
      if (consume) begin
        phase_r <= phase_nxt;
        point_r <= point_nxt;
        exp_r   <= exp_nxt;
        rdig_r  <= rdig_nxt;
        minus_r <= minus_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      begin_r <= in_ch.begin_req;
      ch_r    <= in_ch.ch;
      eol_r   <= in_ch.line_end;
    end
    if (consume && cnt != 2'd0) begin
      fifo_r[wptr_r] <= res0;
    end
    if (consume && cnt == 2'd2) begin
      fifo_r[wptr_r + 2'd1] <= res1;
    end
  end

endmodule
